// ----- hdl/fpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared widths, codes and controller/datapath link types for the file
// permission table.
// ----------------------------------------------------------------------------
package fpt_pkg;

   // default sizing
   localparam int TableEntriesDefault = 256;
   localparam int KeyBitsDefault      = 32;

   // fixed field widths
   localparam int FuncWidth       = 3;
   localparam int FileKeyWidth    = 32;
   localparam int IdWidth         = 8;
   localparam int AccessTextWidth = 48;
   localparam int StatusWidth     = 3;
   localparam int EntryIndexWidth = 8;
   localparam int RightsWidth     = 6;

   // rights text characters
   localparam logic [7:0] CharRead  = 8'h72;
   localparam logic [7:0] CharWrite = 8'h77;
   localparam logic [7:0] CharDash  = 8'h2D;

   // command codes
   typedef enum logic [FuncWidth-1:0] {
      FUNC_CREATE     = 3'd0,
      FUNC_READ_BEGIN = 3'd1,
      FUNC_WRITE_BEGIN = 3'd2,
      FUNC_CHANGE_MODE = 3'd3,
      FUNC_RELEASE    = 3'd4
   } func_type;

   // result codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_DENIED   = 3'd1,
      STATUS_NO_FILE  = 3'd2,
      STATUS_OCCUPIED = 3'd3,
      STATUS_BAD_TEXT = 3'd4,
      STATUS_EXISTS   = 3'd5,
      STATUS_FULL     = 3'd6
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit;
   } fpt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
   } fpt_stat_type;

endpackage

// ----- hdl/fpt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface fpt_req_if;
   import fpt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FuncWidth-1:0]       func;
   logic [FileKeyWidth-1:0]    file_key;
   logic [IdWidth-1:0]         user_id;
   logic [IdWidth-1:0]         group_id;
   logic [AccessTextWidth-1:0] access_text;

   modport source (
      output valid, func, file_key, user_id, group_id, access_text,
      input  ready
   );

   modport sink (
      input  valid, func, file_key, user_id, group_id, access_text,
      output ready
   );

endinterface

// ----- hdl/fpt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_rsp_if
// Result channel: valid/ready handshake with status and entry index.
// ----------------------------------------------------------------------------
interface fpt_rsp_if;
   import fpt_pkg::*;

   logic                       valid;
   logic                       ready;
   status_type                 status;
   logic [EntryIndexWidth-1:0] entry_index;

   modport source (
      output valid, status, entry_index,
      input  ready
   );

   modport sink (
      input  valid, status, entry_index,
      output ready
   );

endinterface

// ----- hdl/fpt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_ctrl
// Command sequencer: accepts a command, runs the key scan, commits the
// update and holds the result until it is taken.
// ----------------------------------------------------------------------------
module fpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpt_pkg::fpt_cmd_type cmd,
   input  fpt_pkg::fpt_stat_type stat
);
   import fpt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // state and handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= S_SEARCH;
                  req_ready_ff <= 1'b0;
               end
            end
            S_SEARCH: begin
               if (stat.scan_done) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath commands
   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && req_valid && req_ready_ff;
      cmd.scan_step = (state_ff == S_SEARCH);
      cmd.commit    = (state_ff == S_EXEC);
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/fpt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_datapath
// Entry memory, entry count, command registers, sequential key scan and
// the decision and update logic for one command.
// ----------------------------------------------------------------------------
module fpt_datapath #(
   parameter int TABLE_ENTRIES = fpt_pkg::TableEntriesDefault,
   parameter int KEY_BITS      = fpt_pkg::KeyBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fpt_pkg::fpt_cmd_type                  cmd,
   output fpt_pkg::fpt_stat_type                 stat,
   input  logic [fpt_pkg::FuncWidth-1:0]         req_func,
   input  logic [fpt_pkg::FileKeyWidth-1:0]      req_file_key,
   input  logic [fpt_pkg::IdWidth-1:0]           req_user_id,
   input  logic [fpt_pkg::IdWidth-1:0]           req_group_id,
   input  logic [fpt_pkg::AccessTextWidth-1:0]   req_access_text,
   output fpt_pkg::status_type                   rsp_status,
   output logic [fpt_pkg::EntryIndexWidth-1:0]   rsp_entry_index
);
   import fpt_pkg::*;

   localparam int IdxW    = $clog2(TABLE_ENTRIES);
   localparam int CntW    = $clog2(TABLE_ENTRIES + 1);
   localparam int KeyW    = (KEY_BITS < FileKeyWidth) ? KEY_BITS : FileKeyWidth;
   localparam int WideIdxW = IdxW + EntryIndexWidth;

   typedef enum logic [1:0] {
      BUSY_IDLE    = 2'd0,
      BUSY_READING = 2'd1,
      BUSY_WRITING = 2'd2
   } busy_type;

   // decode six rights characters; bit 6 flags a valid text
   function automatic logic [RightsWidth:0] parse_rights(
      input logic [AccessTextWidth-1:0] text
   );
      logic [RightsWidth-1:0] bits;
      logic                   ok;
      logic [7:0]             ch;
      logic [7:0]             want;
      bits = '0;
      ok   = 1'b1;
      for (int i = 0; i < RightsWidth; i++) begin
         ch   = text[AccessTextWidth-1-8*i -: 8];
         want = ((i % 2) == 1) ? CharWrite : CharRead;
         bits[RightsWidth-1-i] = (ch == want);
         if ((ch != want) && (ch != CharDash)) begin
            ok = 1'b0;
         end
      end
      return {ok, bits};
   endfunction

   // entry memory
   logic [KeyW-1:0]        mem_key    [TABLE_ENTRIES];
   logic [IdWidth-1:0]     mem_owner  [TABLE_ENTRIES];
   logic [IdWidth-1:0]     mem_group  [TABLE_ENTRIES];
   logic [RightsWidth-1:0] mem_rights [TABLE_ENTRIES];
   logic [1:0]             mem_busy   [TABLE_ENTRIES];

   // command registers
   logic [FuncWidth-1:0]       func_ff;
   logic [KeyW-1:0]            key_ff;
   logic [IdWidth-1:0]         user_ff;
   logic [IdWidth-1:0]         group_ff;
   logic [AccessTextWidth-1:0] text_ff;

   // table fill and scan state
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        scan_addr_ff;
   logic                   rd_valid_ff;
   logic [IdxW-1:0]        rd_addr_ff;
   logic [KeyW-1:0]        rd_key_ff;
   logic [IdWidth-1:0]     rd_owner_ff;
   logic [IdWidth-1:0]     rd_group_ff;
   logic [RightsWidth-1:0] rd_rights_ff;
   logic [1:0]             rd_busy_ff;
   logic                   hit_ff;
   logic [IdxW-1:0]        hit_idx_ff;
   logic [IdWidth-1:0]     hit_owner_ff;
   logic [IdWidth-1:0]     hit_group_ff;
   logic [RightsWidth-1:0] hit_rights_ff;
   logic [1:0]             hit_busy_ff;

   // result registers
   status_type                 status_ff;
   logic [EntryIndexWidth-1:0] index_ff;

   logic                   scan_issue;
   logic                   scan_match;
   logic [RightsWidth:0]   parsed;
   logic                   text_ok;
   logic [1:0]             class_bits;
   status_type             res_status;
   logic [IdxW-1:0]        res_index;
   logic                   wr_new;
   logic                   wr_busy_en;
   logic                   wr_rights_en;
   logic [1:0]             wr_busy_val;
   logic [IdxW-1:0]        wr_addr;
   logic [WideIdxW-1:0]    wide_index;

   // scan issues one read a cycle below the fill count until a hit
   assign scan_issue = cmd.scan_step && !hit_ff && !scan_match && (scan_addr_ff < count_ff);
   assign scan_match = rd_valid_ff && (rd_key_ff == key_ff) && !hit_ff;
   assign stat.scan_done = hit_ff || (!rd_valid_ff && (scan_addr_ff >= count_ff));

   // command capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         key_ff   <= req_file_key[KeyW-1:0];
         user_ff  <= req_user_id;
         group_ff <= req_group_id;
         text_ff  <= req_access_text;
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (cmd.load) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         rd_valid_ff <= scan_issue;
         if (scan_issue) begin
            scan_addr_ff <= scan_addr_ff + CntW'(1);
         end
         if (scan_match) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // matched entry capture
   always_ff @(posedge clock) begin
      if (scan_match) begin
         hit_idx_ff    <= rd_addr_ff;
         hit_owner_ff  <= rd_owner_ff;
         hit_group_ff  <= rd_group_ff;
         hit_rights_ff <= rd_rights_ff;
         hit_busy_ff   <= rd_busy_ff;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      rd_addr_ff   <= scan_addr_ff[IdxW-1:0];
      rd_key_ff    <= mem_key[scan_addr_ff[IdxW-1:0]];
      rd_owner_ff  <= mem_owner[scan_addr_ff[IdxW-1:0]];
      rd_group_ff  <= mem_group[scan_addr_ff[IdxW-1:0]];
      rd_rights_ff <= mem_rights[scan_addr_ff[IdxW-1:0]];
      rd_busy_ff   <= mem_busy[scan_addr_ff[IdxW-1:0]];
   end

   // rights class of the requester: owner, then group, then other
   assign parsed  = parse_rights(text_ff);
   assign text_ok = parsed[RightsWidth];
   always_comb begin
      priority if (hit_owner_ff == user_ff) begin
         class_bits = hit_rights_ff[5:4];
      end else if (hit_group_ff == group_ff) begin
         class_bits = hit_rights_ff[3:2];
      end else begin
         class_bits = hit_rights_ff[1:0];
      end
   end

   // command decision
   always_comb begin
      res_status   = STATUS_OK;
      res_index    = '0;
      wr_new       = 1'b0;
      wr_busy_en   = 1'b0;
      wr_rights_en = 1'b0;
      wr_busy_val  = BUSY_IDLE;
      unique case (func_ff)
         FUNC_CREATE: begin
            priority if (hit_ff) begin
               res_status = STATUS_EXISTS;
               res_index  = hit_idx_ff;
            end else if (!text_ok) begin
               res_status = STATUS_BAD_TEXT;
            end else if (count_ff >= CntW'(TABLE_ENTRIES)) begin
               res_status = STATUS_FULL;
            end else begin
               res_index = count_ff[IdxW-1:0];
               wr_new    = 1'b1;
            end
         end
         FUNC_READ_BEGIN: begin
            res_index = hit_idx_ff;
            priority if (!hit_ff) begin
               res_status = STATUS_NO_FILE;
               res_index  = '0;
            end else if (hit_busy_ff == BUSY_WRITING) begin
               res_status = STATUS_OCCUPIED;
            end else if (!class_bits[1]) begin
               res_status = STATUS_DENIED;
            end else begin
               wr_busy_en  = 1'b1;
               wr_busy_val = BUSY_READING;
            end
         end
         FUNC_WRITE_BEGIN: begin
            res_index = hit_idx_ff;
            priority if (!hit_ff) begin
               res_status = STATUS_NO_FILE;
               res_index  = '0;
            end else if (hit_busy_ff != BUSY_IDLE) begin
               res_status = STATUS_OCCUPIED;
            end else if (!class_bits[0]) begin
               res_status = STATUS_DENIED;
            end else begin
               wr_busy_en  = 1'b1;
               wr_busy_val = BUSY_WRITING;
            end
         end
         FUNC_CHANGE_MODE: begin
            res_index = hit_idx_ff;
            priority if (!hit_ff) begin
               res_status = STATUS_NO_FILE;
               res_index  = '0;
            end else if (!text_ok) begin
               res_status = STATUS_BAD_TEXT;
            end else begin
               wr_rights_en = 1'b1;
            end
         end
         FUNC_RELEASE: begin
            res_index = hit_idx_ff;
            if (!hit_ff) begin
               res_status = STATUS_NO_FILE;
               res_index  = '0;
            end else begin
               wr_busy_en  = 1'b1;
               wr_busy_val = BUSY_IDLE;
            end
         end
         default: begin
            res_status = STATUS_OK;
         end
      endcase
   end

   assign wr_addr = wr_new ? count_ff[IdxW-1:0] : hit_idx_ff;

   // memory write port
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (wr_new) begin
            mem_key[wr_addr]   <= key_ff;
            mem_owner[wr_addr] <= user_ff;
            mem_group[wr_addr] <= group_ff;
         end
         if (wr_new || wr_rights_en) begin
            mem_rights[wr_addr] <= parsed[RightsWidth-1:0];
         end
         if (wr_new || wr_busy_en) begin
            mem_busy[wr_addr] <= wr_busy_val;
         end
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit && wr_new) begin
         count_ff <= count_ff + CntW'(1);
      end
   end

   // result registers
   assign wide_index = {{EntryIndexWidth{1'b0}}, res_index};
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= res_status;
         index_ff  <= wide_index[EntryIndexWidth-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_index = index_ff;

endmodule

// ----- hdl/file_permission_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_permission_table
// Table of file entries with owner/group/other rights and busy state.
// ----------------------------------------------------------------------------
// One command is handled at a time. After a command transfer the block scans
// the entry memory one entry per cycle from the first entry up to the first
// matching key (or to the fill count), then decides and updates the entry
// and presents the result. Between one command transfer and the next lie the
// scan, the drain of the registered read, the decision, the result held until
// it is taken, and an idle state before the next command is taken. The single
// read port of the entry memory sets the length of the scan. The next command
// is taken once the result transfer has completed. No clearing pass is needed
// after reset: entries at or above the fill count are never read.
// ----------------------------------------------------------------------------
module file_permission_table #(
   parameter int TABLE_ENTRIES = fpt_pkg::TableEntriesDefault,
   parameter int KEY_BITS      = fpt_pkg::KeyBitsDefault
) (
   input logic      clock,
   input logic      reset,
   fpt_req_if.sink  req_chan,
   fpt_rsp_if.source rsp_chan
);
   import fpt_pkg::*;

   fpt_cmd_type  cmd;
   fpt_stat_type stat;

   // command sequencer
   fpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // entry table and decision logic
   fpt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_chan.func),
      .req_file_key    (req_chan.file_key),
      .req_user_id     (req_chan.user_id),
      .req_group_id    (req_chan.group_id),
      .req_access_text (req_chan.access_text),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_index (rsp_chan.entry_index)
   );

endmodule

// ----- test/fpt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_checker
// Watches the command and result channels of the file permission table,
// keeps its own copy of the entry table, works out the status and entry
// index of every accepted command and compares them with the results in order.
// ----------------------------------------------------------------------------
module fpt_checker (
   input  logic clock,
   input  logic reset,
   fpt_req_if   req_mon,
   fpt_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_pending
);
   import fpt_pkg::*;

   localparam int Entries     = TableEntriesDefault;
   localparam int ReportLimit = 40;

   // busy state of an entry
   localparam logic [1:0] BusyIdle    = 2'd0;
   localparam logic [1:0] BusyReading = 2'd1;
   localparam logic [1:0] BusyWriting = 2'd2;

   typedef struct packed {
      status_type                 status;
      logic [EntryIndexWidth-1:0] entry_index;
   } outcome_type;

   // shadow of the entry table
   logic [FileKeyWidth-1:0] shadow_key    [Entries];
   logic [IdWidth-1:0]      shadow_owner  [Entries];
   logic [IdWidth-1:0]      shadow_group  [Entries];
   logic [RightsWidth-1:0]  shadow_rights [Entries];
   logic [1:0]              shadow_busy   [Entries];
   int                      entry_total = 0;

   outcome_type outcome_queue [$];
   int          mismatches = 0;

   // one line per mismatch, printing stops after a while but counting goes on
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < ReportLimit) begin
         $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   // access text to rights bits, owner r at bit 5 down to other w at bit 0
   function automatic logic decode_rights(input logic [AccessTextWidth-1:0] text,
                                          output logic [RightsWidth-1:0] bits);
      logic [7:0] ch;
      logic [7:0] wanted;
      bits = '0;
      for (int i = 0; i < 6; i++) begin
         ch     = text[AccessTextWidth-1 - 8*i -: 8];
         wanted = (i % 2 == 1) ? CharWrite : CharRead;
         if (ch == wanted) begin
            bits[5-i] = 1'b1;
         end else if (ch != CharDash) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // owner class first, then group, then other
   function automatic logic access_allowed(input int idx, input logic [IdWidth-1:0] user,
                                           input logic [IdWidth-1:0] group,
                                           input logic for_write);
      int shift;
      if (shadow_owner[idx] == user) begin
         shift = 4;
      end else if (shadow_group[idx] == group) begin
         shift = 2;
      end else begin
         shift = 0;
      end
      return shadow_rights[idx][shift + (for_write ? 0 : 1)];
   endfunction

   // status and index of one command, updating the shadow table
   function automatic outcome_type predict_command(input logic [FuncWidth-1:0] code,
                                                   input logic [FileKeyWidth-1:0] key,
                                                   input logic [IdWidth-1:0] user,
                                                   input logic [IdWidth-1:0] group,
                                                   input logic [AccessTextWidth-1:0] text);
      outcome_type            res;
      int                     hit;
      logic                   text_ok;
      logic [RightsWidth-1:0] new_rights;
      res.status      = STATUS_OK;
      res.entry_index = '0;
      hit             = -1;
      text_ok         = decode_rights(text, new_rights);
      for (int i = 0; i < entry_total; i++) begin
         if (hit < 0 && shadow_key[i] == key) hit = i;
      end
      case (code)
         FUNC_CREATE: begin
            if (hit >= 0) begin
               res.status      = STATUS_EXISTS;
               res.entry_index = EntryIndexWidth'(hit);
            end else if (!text_ok) begin
               res.status = STATUS_BAD_TEXT;
            end else if (entry_total >= Entries) begin
               res.status = STATUS_FULL;
            end else begin
               res.entry_index           = EntryIndexWidth'(entry_total);
               shadow_key[entry_total]    = key;
               shadow_owner[entry_total]  = user;
               shadow_group[entry_total]  = group;
               shadow_rights[entry_total] = new_rights;
               shadow_busy[entry_total]   = BusyIdle;
               entry_total++;
            end
         end
         FUNC_READ_BEGIN, FUNC_WRITE_BEGIN, FUNC_CHANGE_MODE, FUNC_RELEASE: begin
            if (hit < 0) begin
               res.status = STATUS_NO_FILE;
            end else begin
               res.entry_index = EntryIndexWidth'(hit);
               case (code)
                  FUNC_READ_BEGIN: begin
                     // readers share, a writer blocks
                     if (shadow_busy[hit] == BusyWriting) begin
                        res.status = STATUS_OCCUPIED;
                     end else if (!access_allowed(hit, user, group, 1'b0)) begin
                        res.status = STATUS_DENIED;
                     end else begin
                        shadow_busy[hit] = BusyReading;
                     end
                  end
                  FUNC_WRITE_BEGIN: begin
                     if (shadow_busy[hit] != BusyIdle) begin
                        res.status = STATUS_OCCUPIED;
                     end else if (!access_allowed(hit, user, group, 1'b1)) begin
                        res.status = STATUS_DENIED;
                     end else begin
                        shadow_busy[hit] = BusyWriting;
                     end
                  end
                  FUNC_CHANGE_MODE: begin
                     if (!text_ok) begin
                        res.status = STATUS_BAD_TEXT;
                     end else begin
                        shadow_rights[hit] = new_rights;
                     end
                  end
                  default: begin
                     shadow_busy[hit] = BusyIdle;
                  end
               endcase
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type expected_outcome;
      if (reset) begin
         entry_total = 0;
         outcome_queue.delete();
      end else begin
         // result transfer against the oldest pending prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_queue.size() == 0) begin
               report_mismatch("result with nothing pending, status",
                               int'(rsp_mon.status), -1);
            end else begin
               expected_outcome = outcome_queue.pop_front();
               if (rsp_mon.status !== expected_outcome.status) begin
                  report_mismatch("status", int'(rsp_mon.status),
                                  int'(expected_outcome.status));
               end
               if (rsp_mon.entry_index !== expected_outcome.entry_index) begin
                  report_mismatch("entry_index", int'(rsp_mon.entry_index),
                                  int'(expected_outcome.entry_index));
               end
            end
         end
         // command transfer: predict and queue
         if (req_mon.valid && req_mon.ready) begin
            outcome_queue.push_back(predict_command(req_mon.func, req_mon.file_key,
                                                    req_mon.user_id, req_mon.group_id,
                                                    req_mon.access_text));
         end
      end
      results_pending <= outcome_queue.size();
      mismatch_count  <= mismatches;
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the file permission table: a directed walk through every
// command and every outcome but a full table, then random traffic that fills
// the table and works on its files in read and write sessions, with bursty
// commands, a stalling result side and one long hold-off. The checker beside
// the block does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import fpt_pkg::*;

   localparam int RandomItems    = 1250;
   localparam int FillTarget     = 280;
   localparam int WatchdogLimit  = 4000;
   localparam int LongHoldStart  = 2500;
   localparam int LongHoldCycles = 500;
   localparam int DrainCycles    = 300;

   typedef enum int {StallNone, StallRandom, StallHeavy, StallPeriodic} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpt_req_if req_chan ();
   fpt_rsp_if rsp_chan ();

   int mismatch_count;
   int results_pending;

   int                      burst_left = 0;
   int                      items_sent = 0;
   logic [FileKeyWidth-1:0] known_keys [$];

   always #10 clock = ~clock;

   file_permission_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fpt_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // small pool of ids so that owner and group matches are frequent
   function automatic logic [IdWidth-1:0] pick_id();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [FileKeyWidth-1:0] pick_known();
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
   endfunction

   function automatic logic [AccessTextWidth-1:0] random_text();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic logic [AccessTextWidth-1:0] rights_text(input logic [RightsWidth-1:0] bits);
      logic [AccessTextWidth-1:0] text;
      for (int i = 0; i < 6; i++) begin
         text[AccessTextWidth-1 - 8*i -: 8] =
            bits[5-i] ? ((i % 2 == 1) ? CharWrite : CharRead) : CharDash;
      end
      return text;
   endfunction

   // either noise or a well-formed text with a single flipped bit
   function automatic logic [AccessTextWidth-1:0] bad_text();
      logic [AccessTextWidth-1:0] text;
      int                         pos;
      if ($urandom_range(0, 2) == 0) return random_text();
      text = rights_text(RightsWidth'($urandom()));
      pos  = $urandom_range(0, 5);
      text[AccessTextWidth-1 - 8*pos -: 8] ^= 8'(1 << $urandom_range(0, 7));
      return text;
   endfunction

   // one command transfer, opening a new burst after a random gap when due
   task automatic send_command(input logic [FuncWidth-1:0] code,
                               input logic [FileKeyWidth-1:0] key,
                               input logic [IdWidth-1:0] user,
                               input logic [IdWidth-1:0] group,
                               input logic [AccessTextWidth-1:0] text);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
         end else if ($urandom_range(0, 19) == 0) begin
            gap = $urandom_range(20, 300);
         end else begin
            gap = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 6);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= code;
      req_chan.file_key    <= key;
      req_chan.user_id     <= user;
      req_chan.group_id    <= group;
      req_chan.access_text <= text;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (code == FUNC_CREATE) known_keys.push_back(key);
   endtask

   // result side: changing stall patterns and one long hold-off
   initial begin : result_stall
      int             cycle_no;
      stall_mode_type stall_mode;
      cycle_no   = 0;
      stall_mode = StallNone;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no == LongHoldStart) begin
            rsp_chan.ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end
         if (cycle_no % 150 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            StallNone:   rsp_chan.ready <= 1'b1;
            StallRandom: rsp_chan.ready <= 1'($urandom_range(0, 1));
            StallHeavy:  rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            default:     rsp_chan.ready <= (cycle_no % 3 != 0);
         endcase
      end
   end

   // ends the run when nothing is transferred for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [FileKeyWidth-1:0]    key;
      logic [AccessTextWidth-1:0] text;
      logic [FuncWidth-1:0]       code;
      int                         choice;
      int                         random_goal;
      int                         fresh_creates;
      int                         session_len;
      logic                       fresh;

      req_chan.valid       <= 1'b0;
      req_chan.func        <= '0;
      req_chan.file_key    <= '0;
      req_chan.user_id     <= '0;
      req_chan.group_id    <= '0;
      req_chan.access_text <= '0;
      fresh_creates = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, creates, key extremes, bad texts
      send_command(FUNC_READ_BEGIN, 32'h0000_0000, 8'd0, 8'd0, "rwrwrw");
      send_command(FUNC_CREATE, 32'h0000_0000, 8'd0, 8'd0, "rwrwrw");
      send_command(FUNC_CREATE, 32'hFFFF_FFFF, 8'd255, 8'd255, "------");
      send_command(FUNC_CREATE, 32'h0000_0000, 8'd7, 8'd7, "rwrwrw");
      send_command(FUNC_CREATE, 32'h0000_0005, 8'd0, 8'd0, "rwrwrx");
      send_command(FUNC_CREATE, 32'h0000_0005, 8'd0, 8'd0, "wrwrwr");
      send_command(FUNC_CREATE, 32'h1234_5678, 8'd1, 8'd2, "rwr---");
      // shared readers, then a writer locked out
      send_command(FUNC_READ_BEGIN, 32'h1234_5678, 8'd1, 8'd9, "------");
      send_command(FUNC_READ_BEGIN, 32'h1234_5678, 8'd3, 8'd2, "------");
      send_command(FUNC_WRITE_BEGIN, 32'h1234_5678, 8'd1, 8'd2, "------");
      send_command(FUNC_RELEASE, 32'h1234_5678, 8'd1, 8'd2, "------");
      // rights by class: group and other refused, owner allowed
      send_command(FUNC_WRITE_BEGIN, 32'h1234_5678, 8'd3, 8'd2, "------");
      send_command(FUNC_WRITE_BEGIN, 32'h1234_5678, 8'd9, 8'd9, "------");
      send_command(FUNC_READ_BEGIN, 32'h1234_5678, 8'd9, 8'd9, "------");
      send_command(FUNC_WRITE_BEGIN, 32'h1234_5678, 8'd1, 8'd0, "------");
      send_command(FUNC_READ_BEGIN, 32'h1234_5678, 8'd1, 8'd0, "------");
      send_command(FUNC_WRITE_BEGIN, 32'h1234_5678, 8'd1, 8'd0, "------");
      send_command(FUNC_RELEASE, 32'h1234_5678, 8'd9, 8'd9, "------");
      // mode change by anyone, invalid text and missing files
      send_command(FUNC_CHANGE_MODE, 32'h1234_5678, 8'd200, 8'd200, "------");
      send_command(FUNC_READ_BEGIN, 32'h1234_5678, 8'd1, 8'd2, "------");
      send_command(FUNC_CHANGE_MODE, 32'h1234_5678, 8'd1, 8'd2, "r-r-rr");
      send_command(FUNC_CHANGE_MODE, 32'h0000_0005, 8'd1, 8'd2, "rwrwrw");
      send_command(FUNC_RELEASE, 32'h0000_0005, 8'd1, 8'd2, "------");
      send_command(FUNC_RELEASE, 32'h0000_0000, 8'd0, 8'd0, "------");
      send_command(FUNC_CHANGE_MODE, 32'hFFFF_FFFF, 8'd0, 8'd0, "rwrwrw");
      // unused command codes
      for (int unused = FUNC_RELEASE + 1; unused < 8; unused++) begin
         send_command(FuncWidth'(unused), $urandom(), pick_id(), pick_id(), random_text());
      end

      // random: heavy creation until the table is full, then mostly sessions
      random_goal = items_sent + RandomItems;
      while (items_sent < random_goal) begin
         choice = $urandom_range(0, 99);
         if (choice < ((fresh_creates < FillTarget) ? 70 : 15)) begin
            fresh = ($urandom_range(0, 4) != 0);
            key   = fresh ? $urandom() : pick_known();
            if ($urandom_range(0, 9) != 0) begin
               text = rights_text(RightsWidth'($urandom()));
               if (fresh) fresh_creates++;
            end else begin
               text = bad_text();
            end
            send_command(FUNC_CREATE, key, pick_id(), pick_id(), text);
         end else if (choice < 85) begin
            // a session on one file: begins, perhaps a mode change, then usually a release
            key         = pick_known();
            session_len = $urandom_range(1, 3);
            repeat (session_len) begin
               send_command($urandom_range(0, 1) ? FUNC_READ_BEGIN : FUNC_WRITE_BEGIN,
                            key, pick_id(), pick_id(), random_text());
            end
            if ($urandom_range(0, 3) == 0) begin
               text = ($urandom_range(0, 4) != 0) ? rights_text(RightsWidth'($urandom()))
                                                  : bad_text();
               send_command(FUNC_CHANGE_MODE, key, pick_id(), pick_id(), text);
            end
            if ($urandom_range(0, 4) != 0) begin
               send_command(FUNC_RELEASE, key, pick_id(), pick_id(), random_text());
            end
         end else begin
            // lone command, often on a missing file or an unused code
            code = FuncWidth'($urandom_range(1, 7));
            key  = $urandom_range(0, 1) ? pick_known() : $urandom();
            text = $urandom_range(0, 1) ? rights_text(RightsWidth'($urandom())) : bad_text();
            send_command(code, key, pick_id(), pick_id(), text);
         end
      end
      req_chan.valid <= 1'b0;

      // drain outstanding results, then watch for strays
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
